[rtl/tcpop_pkg.sv]
package tcpop_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CODE_W  = 3;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned ACCUM_W = 64;

   // Option kinds on the wire
   localparam logic [BYTE_W-1:0] KIND_EOL   = 8'd0;
   localparam logic [BYTE_W-1:0] KIND_NOP   = 8'd1;
   localparam logic [BYTE_W-1:0] KIND_MSS   = 8'd2;
   localparam logic [BYTE_W-1:0] KIND_WSCL  = 8'd3;
   localparam logic [BYTE_W-1:0] KIND_SACKP = 8'd4;
   localparam logic [BYTE_W-1:0] KIND_TSTMP = 8'd8;

   // Smallest length byte that covers kind and length
   localparam logic [BYTE_W-1:0] HDR_BYTES = 8'd2;

   // Record codes
   localparam logic [CODE_W-1:0] REC_MSS   = 3'd0;
   localparam logic [CODE_W-1:0] REC_WSCL  = 3'd1;
   localparam logic [CODE_W-1:0] REC_SACKP = 3'd2;
   localparam logic [CODE_W-1:0] REC_TSTMP = 3'd3;
   localparam logic [CODE_W-1:0] REC_END   = 3'd4;
   localparam logic [CODE_W-1:0] REC_TRUNC = 3'd5;

   typedef enum logic [1:0] {
      PH_KIND  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2,
      PH_SKIP  = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [BYTE_W-1:0]    kind;
      logic [BYTE_W-1:0]    len;
      logic [BYTE_W-1:0]    left;
      logic [ACCUM_W-1:0]   accum;
      logic [COUNT_W-1:0]   found;
   } state_type;

   typedef struct packed {
      logic [CODE_W-1:0]    record_kind;
      logic [BYTE_W-1:0]    declared_len;
      logic [15:0]          mss_value;
      logic [BYTE_W-1:0]    shift_count;
      logic [ACCUM_W-1:0]   stamp_value;
      logic [COUNT_W-1:0]   option_number;
      logic                 is_last;
   } rec_type;

   localparam state_type STATE_RESET = '{PH_KIND, 8'd0, 8'd0, 8'd0, 64'd0, 5'd0};

   function automatic logic kind_known(input logic [BYTE_W-1:0] kind);
      logic hit;
      case (kind)
         KIND_MSS, KIND_WSCL, KIND_SACKP, KIND_TSTMP: hit = 1'b1;
         default:                                     hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic [CODE_W-1:0] kind_code(input logic [BYTE_W-1:0] kind);
      logic [CODE_W-1:0] code;
      case (kind)
         KIND_MSS:   code = REC_MSS;
         KIND_WSCL:  code = REC_WSCL;
         KIND_SACKP: code = REC_SACKP;
         KIND_TSTMP: code = REC_TSTMP;
         default:    code = REC_TRUNC;
      endcase
      return code;
   endfunction

   function automatic logic [BYTE_W-1:0] value_bytes(input logic [BYTE_W-1:0] kind);
      logic [BYTE_W-1:0] n;
      case (kind)
         KIND_MSS:   n = 8'd2;
         KIND_WSCL:  n = 8'd1;
         KIND_TSTMP: n = 8'd8;
         default:    n = 8'd0;
      endcase
      return n;
   endfunction

endpackage

[rtl/tcpop_if.sv]
interface tcpop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] opt_byte;
   logic       list_last;

   modport source (output valid, output opt_byte, output list_last, input ready);
   modport sink   (input valid, input opt_byte, input list_last, output ready);
endinterface

interface tcpop_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  record_kind;
   logic [7:0]  declared_len;
   logic [15:0] mss_value;
   logic [7:0]  shift_count;
   logic [63:0] stamp_value;
   logic [4:0]  option_number;
   logic        is_last;

   modport source (output valid, output record_kind, output declared_len, output mss_value,
                   output shift_count, output stamp_value, output option_number,
                   output is_last, input ready);
   modport sink   (input valid, input record_kind, input declared_len, input mss_value,
                   input shift_count, input stamp_value, input option_number,
                   input is_last, output ready);
endinterface

[rtl/tcpop_step.sv]
module tcpop_step #(
   parameter int unsigned FOUND_CAP = 20
) (
   input  tcpop_pkg::state_type state_cur,
   input  logic [7:0]           opt_byte,
   input  logic                 list_last,
   output tcpop_pkg::state_type state_nxt,
   output logic                 emit,
   output tcpop_pkg::rec_type   rec
);
   import tcpop_pkg::*;

   localparam logic [COUNT_W-1:0] CAP = COUNT_W'(FOUND_CAP);

   logic                fin;
   logic [BYTE_W-1:0]   need;
   logic [BYTE_W-1:0]   left_dec;
   logic [CODE_W-1:0]   code;

   assign need     = value_bytes(state_cur.kind);
   assign left_dec = state_cur.left - {7'd0, state_cur.left != 8'd0};
   assign code     = kind_code(state_cur.kind);

   always_comb begin
      state_nxt = state_cur;
      fin       = 1'b0;
      emit      = 1'b0;
      rec       = '0;

      unique case (state_cur.phase)
         PH_KIND: begin
            if (opt_byte != KIND_EOL && opt_byte != KIND_NOP) begin
               state_nxt.kind  = opt_byte;
               state_nxt.phase = PH_LEN;
            end
         end
         PH_LEN: begin
            state_nxt.len   = opt_byte;
            state_nxt.accum = '0;
            if (kind_known(state_cur.kind)) begin
               if (need == 8'd0) begin
                  fin = 1'b1;
               end else begin
                  state_nxt.left  = need;
                  state_nxt.phase = PH_VALUE;
               end
            end else if (opt_byte > HDR_BYTES) begin
               state_nxt.left  = opt_byte - HDR_BYTES;
               state_nxt.phase = PH_SKIP;
            end else begin
               state_nxt.phase = PH_KIND;
            end
         end
         PH_VALUE: begin
            state_nxt.accum = {state_cur.accum[ACCUM_W-BYTE_W-1:0], opt_byte};
            state_nxt.left  = left_dec;
            if (left_dec == 8'd0) fin = 1'b1;
         end
         PH_SKIP: begin
            state_nxt.left = left_dec;
            if (left_dec == 8'd0) state_nxt.phase = PH_KIND;
         end
         default: state_nxt = state_cur;
      endcase

      if (fin) begin
         if (state_cur.found < CAP) state_nxt.found = state_cur.found + 5'd1;
         state_nxt.phase   = PH_KIND;
         emit              = 1'b1;
         rec.record_kind   = code;
         rec.declared_len  = state_nxt.len;
         rec.mss_value     = (code == REC_MSS)   ? state_nxt.accum[15:0] : 16'd0;
         rec.shift_count   = (code == REC_WSCL)  ? state_nxt.accum[7:0]  : 8'd0;
         rec.stamp_value   = (code == REC_TSTMP) ? state_nxt.accum       : 64'd0;
         rec.option_number = state_nxt.found;
      end

      if (list_last) begin
         if (!fin) begin
            rec.record_kind   = (state_nxt.phase == PH_KIND) ? REC_END : REC_TRUNC;
            rec.option_number = state_nxt.found;
         end
         rec.is_last = 1'b1;
         emit        = 1'b1;
         state_nxt   = STATE_RESET;
      end
   end

endmodule

[rtl/tcp_option_parser.sv]
// TCP options parser.
// req_ch carries the options area one byte per transaction (opt_byte), with
// list_last set on its final byte. rsp_ch carries one record per recognized
// option (MSS, window scale, SACK permitted, timestamp) as it completes, plus
// a list-end or truncated record on the final byte when that byte does not
// itself complete an option. Other kinds are skipped by their length byte.
// Most bytes produce no record.
// Timing: a byte is taken into the input register, parsed once the output
// register is free, and its record, if any, is held in the output register,
// which drives rsp_ch.valid. One byte per cycle sustained while rsp_ch is not
// stalled; the parser state update is combinational, so there is no loop limit.
// Stall: while a record waits on rsp_ch.ready, the input register still
// takes one more byte; parsing of it waits until the output register frees.
// Bytes that produce no record never wait on the output side once it is free.
// Reset: synchronous; clears both registers' valid flags and the parser
// state (expecting a kind byte, option count zero). State also returns to
// that point after every final byte.
module tcp_option_parser #(
   parameter int unsigned MAX_OPTION_BYTES = 40
) (
   input  logic               clock,
   input  logic               reset,
   tcpop_req_if.sink          req_ch,
   tcpop_rsp_if.source        rsp_ch
);
   import tcpop_pkg::*;

   localparam int unsigned FOUND_CAP = MAX_OPTION_BYTES / 2;

   // input register
   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;

   // parser state
   state_type         state_ff;
   state_type         state_in;

   // output register
   logic              rsp_valid_ff;
   rec_type           rsp_ff;
   rec_type           rec_in;
   logic              emit;

   logic              out_free;
   logic              s1_go;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;

   tcpop_step #(
      .FOUND_CAP (FOUND_CAP)
   ) u_step (
      .state_cur (state_ff),
      .opt_byte  (s1_byte_ff),
      .list_last (s1_last_ff),
      .state_nxt (state_in),
      .emit      (emit),
      .rec       (rec_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_ch.ready) s1_valid_ff <= req_ch.valid;
         if (s1_go) state_ff <= state_in;
         if (out_free) rsp_valid_ff <= s1_go && emit;
      end
      // payload, no reset
      if (req_ch.valid && req_ch.ready) begin
         s1_byte_ff <= req_ch.opt_byte;
         s1_last_ff <= req_ch.list_last;
      end
      if (s1_go && emit) rsp_ff <= rec_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.record_kind   = rsp_ff.record_kind;
   assign rsp_ch.declared_len  = rsp_ff.declared_len;
   assign rsp_ch.mss_value     = rsp_ff.mss_value;
   assign rsp_ch.shift_count   = rsp_ff.shift_count;
   assign rsp_ch.stamp_value   = rsp_ff.stamp_value;
   assign rsp_ch.option_number = rsp_ff.option_number;
   assign rsp_ch.is_last       = rsp_ff.is_last;

   // end and truncation records only come from the final byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.record_kind == REC_END || rsp_ff.record_kind == REC_TRUNC)
      |-> rsp_ff.is_last)
      else $error("end record without is_last");

   // a parsed final byte restarts the list
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=> state_ff.phase == PH_KIND && state_ff.found == '0)
      else $error("state not cleared after final byte");

   // option count never passes its cap
   a_found_cap: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> state_ff.found <= COUNT_W'(FOUND_CAP))
      else $error("option count overflow");

   // a waiting record is not replaced while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("stalled record changed");

endmodule
